@@ rtl/core/tlmi_pkg.sv @@
// shared constants and beat types of the three-axis linear move interpolator
package tlmi_pkg;

  localparam int unsigned AXES        = 3;
  localparam int unsigned ANGLE_WIDTH = 16;
  localparam int unsigned T_FRAC_BITS = 16;
  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned DUR_WIDTH   = 16;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

  typedef struct packed {
    logic                  cmd;
    logic [TIME_WIDTH-1:0] now_ms;
    angle_t                target_angle_1;
    angle_t                target_angle_2;
    angle_t                target_angle_3;
    logic [DUR_WIDTH-1:0]  move_duration_ms;
  } in_t;

  typedef struct packed {
    angle_t angle_1;
    angle_t angle_2;
    angle_t angle_3;
    logic   motion_done;
  } out_t;

endpackage

@@ rtl/core/three_axis_linear_move_interpolator.sv @@
// three-axis timed linear move interpolator with bit-serial divide and multiply
//
// A start beat either jumps to its targets at once (duration 0, one result with
// motion_done set) or loads a move and gives no result. An update beat while a
// move runs gives one result. An update beat whose move is complete (elapsed
// time at or past the duration) gives the end angles directly. Any other update
// runs a restoring divider one quotient bit per cycle and then a shift-add
// multiplier one bit of t per cycle for all three axes in parallel, and its
// result then goes to the output register. The output register lets the result
// wait while the next beat is taken.
module three_axis_linear_move_interpolator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tlmi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tlmi_pkg::out_t out_data_o
);

  localparam int unsigned AW    = tlmi_pkg::ANGLE_WIDTH;
  localparam int unsigned TB    = tlmi_pkg::T_FRAC_BITS;
  localparam int unsigned DW    = tlmi_pkg::DUR_WIDTH;
  localparam int unsigned TW    = tlmi_pkg::TIME_WIDTH;
  localparam int unsigned NAX   = tlmi_pkg::AXES;
  localparam int unsigned ACC_W = AW + 2;
  localparam int unsigned CNT_W = $clog2(TB);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV    = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  tlmi_pkg::angle_t cur_q   [NAX];
  tlmi_pkg::angle_t start_q [NAX];
  tlmi_pkg::angle_t end_q   [NAX];
  tlmi_pkg::angle_t res_q   [NAX];
  tlmi_pkg::angle_t res_d   [NAX];
  logic signed [ACC_W-1:0] acc_q [NAX];
  logic signed [ACC_W-1:0] acc_d [NAX];
  logic signed [ACC_W:0]   mul_sum [NAX];
  logic signed [AW:0]      diff    [NAX];
  tlmi_pkg::angle_t tgt [NAX];

  logic [TW-1:0]    start_time_q;
  logic [DW-1:0]    len_q;
  logic             moving_q;
  logic             res_done_q;
  logic [DW-1:0]    rem_q, rem_d;
  logic [TB-1:0]    t_q, t_d;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  tlmi_pkg::out_t   out_q, out_pack;

  logic          in_acc, out_free, cnt_last, t_full, div_ge;
  logic [TW-1:0] elapsed;
  logic [DW:0]   rem_sh, rem_sub;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cnt_last    = (cnt_q == CNT_W'(TB - 1));

  assign tgt[0] = in_data_i.target_angle_1;
  assign tgt[1] = in_data_i.target_angle_2;
  assign tgt[2] = in_data_i.target_angle_3;

  // an elapsed time at or past the duration means t is full
  assign elapsed = in_data_i.now_ms - start_time_q;
  assign t_full  = (len_q == '0) || (elapsed >= TW'(len_q));

  // one restoring divide step: remainder stays below the length
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, len_q};
  assign div_ge  = (rem_sh >= {1'b0, len_q});
  assign rem_d   = div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];

  always_comb begin
    t_d = t_q;
    unique case (state_q)
      ST_DIV:  t_d = {t_q[TB-2:0], div_ge};
      ST_MUL:  t_d = t_q >> 1;
      default: t_d = t_q;
    endcase
  end

  // lsb-first shift-add, each step floors by two so the end value is floor(t*diff/2^TB)
  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      diff[a]    = {end_q[a][AW-1], end_q[a]} - {start_q[a][AW-1], start_q[a]};
      mul_sum[a] = {acc_q[a][ACC_W-1], acc_q[a]}
                 + (t_q[0] ? (ACC_W+1)'(diff[a]) : '0);
      acc_d[a]   = mul_sum[a][ACC_W:1];
      res_d[a]   = start_q[a] + acc_d[a][AW-1:0];
    end
  end

  always_comb begin
    out_pack.angle_1     = res_q[0];
    out_pack.angle_2     = res_q[1];
    out_pack.angle_3     = res_q[2];
    out_pack.motion_done = res_done_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.cmd == tlmi_pkg::CMD_START) begin
            if (in_data_i.move_duration_ms == '0) state_d = ST_RESULT;
          end else if (moving_q) begin
            state_d = t_full ? ST_RESULT : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      moving_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      start_time_q <= '0;
      len_q        <= '0;
      for (int a = 0; a < NAX; a++) begin
        cur_q[a]   <= '0;
        start_q[a] <= '0;
        end_q[a]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_acc && in_data_i.cmd == tlmi_pkg::CMD_START) begin
            if (in_data_i.move_duration_ms == '0) begin
              moving_q <= 1'b0;
            end else begin
              moving_q     <= 1'b1;
              start_time_q <= in_data_i.now_ms;
              len_q        <= in_data_i.move_duration_ms;
              for (int a = 0; a < NAX; a++) begin
                start_q[a] <= cur_q[a];
                end_q[a]   <= tgt[a];
              end
            end
          end
        end
        ST_DIV, ST_MUL: begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_RESULT: begin
          if (out_free) begin
            if (res_done_q) moving_q <= 1'b0;
            for (int a = 0; a < NAX; a++) cur_q[a] <= res_q[a];
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    unique case (state_q)
      ST_IDLE: begin
        rem_q <= elapsed[DW-1:0];
        for (int a = 0; a < NAX; a++) acc_q[a] <= '0;
        if (in_acc) begin
          if (in_data_i.cmd == tlmi_pkg::CMD_START) begin
            res_done_q <= 1'b1;
            for (int a = 0; a < NAX; a++) res_q[a] <= tgt[a];
          end else begin
            // full t lands exactly on the end angles
            res_done_q <= 1'b1;
            for (int a = 0; a < NAX; a++) res_q[a] <= end_q[a];
          end
        end
      end
      ST_DIV: begin
        rem_q <= rem_d;
      end
      ST_MUL: begin
        for (int a = 0; a < NAX; a++) acc_q[a] <= acc_d[a];
        if (cnt_last) begin
          res_done_q <= 1'b0;
          for (int a = 0; a < NAX; a++) res_q[a] <= res_d[a];
        end
      end
      ST_RESULT: begin
        if (out_free) out_q <= out_pack;
      end
      default: rem_q <= rem_q;
    endcase
  end

`ifndef SYNTHESIS
  a_done_ends_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_free) |=> (out_q.motion_done != moving_q))
    else $error("motion_done disagrees with move state");

  a_mul_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> moving_q)
    else $error("interpolation running without an active move");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < len_q))
    else $error("divider remainder not below move length");
`endif

endmodule
